// ===== hdl/i2cs_pkg.sv =====
// shared types and codes for the i2c master transaction sequencer
package i2cs_pkg;

  // item kinds carried on the input tuser
  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeWrite  = 2'd1;
  localparam logic [1:0] ModeRead   = 2'd2;
  localparam logic [1:0] ModeStatus = 2'd3;

  // bus actions
  localparam logic [2:0] ActNone   = 3'd0;
  localparam logic [2:0] ActStart  = 3'd1;
  localparam logic [2:0] ActSend   = 3'd2;
  localparam logic [2:0] ActRxAck  = 3'd3;
  localparam logic [2:0] ActRxNack = 3'd4;
  localparam logic [2:0] ActStop   = 3'd5;

  // bus status codes after masking
  localparam logic [7:0] StatusMask    = 8'hF8;
  localparam logic [7:0] StStart       = 8'h08;
  localparam logic [7:0] StRepStart    = 8'h10;
  localparam logic [7:0] StAddrWAck    = 8'h18;
  localparam logic [7:0] StDataWAck    = 8'h28;
  localparam logic [7:0] StAddrRAck    = 8'h40;
  localparam logic [7:0] StDataRAck    = 8'h50;
  localparam logic [7:0] StDataRNack   = 8'h58;
  localparam logic       ReadDirBit    = 1'b1;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] slave_addr;
    logic [5:0] xfer_length;
    logic [4:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] bus_status;
    logic [7:0] bus_rx_byte;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] bus_action;
    logic [7:0] out_byte;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_data;
    logic       complete;
    logic       success;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic       active;
    logic [7:0] addr_byte;
    logic [5:0] length_left;
    logic [5:0] byte_count;
  } seq_state_t;

endpackage

// ===== hdl/i2cs_ram.sv =====
// generic single write port ram with registered read
module i2cs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/i2cs_step.sv =====
// result and next sequencer state for one word
module i2cs_step #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  i2cs_pkg::item_t      item_i,
  input  i2cs_pkg::seq_state_t state_i,
  input  logic [7:0]           tx_byte_i,
  output i2cs_pkg::result_t    res_o,
  output i2cs_pkg::seq_state_t state_o
);
  import i2cs_pkg::*;

  logic [7:0] status_m;
  logic       is_read;
  logic       start_ok;
  logic [5:0] bc_inc;

  assign status_m = item_i.bus_status & StatusMask;
  assign is_read  = (state_i.addr_byte[0] == ReadDirBit);
  assign bc_inc   = state_i.byte_count + 6'd1;
  assign start_ok = !state_i.active
                    && (9'(item_i.xfer_length) <= 9'(BUF_DEPTH))
                    && !((item_i.mode == ModeRead) && (item_i.xfer_length == 6'd0));

  always_comb begin
    res_o   = '0;
    state_o = state_i;
    unique case (item_i.mode)
      ModeLoad: begin
        // store write happens at the ram port
      end
      ModeWrite, ModeRead: begin
        if (start_ok) begin
          state_o.addr_byte   = {item_i.slave_addr, (item_i.mode == ModeRead)};
          state_o.length_left = item_i.xfer_length;
          state_o.byte_count  = 6'd0;
          state_o.active      = 1'b1;
          res_o.accepted      = 1'b1;
          res_o.bus_action    = ActStart;
        end
      end
      ModeStatus: begin
        if (state_i.active) begin
          if (status_m == StStart || status_m == StRepStart) begin
            res_o.bus_action = ActSend;
            res_o.out_byte   = state_i.addr_byte;
          end else if ((status_m == StAddrWAck || status_m == StDataWAck) && !is_read) begin
            if (state_i.byte_count < state_i.length_left) begin
              res_o.bus_action   = ActSend;
              res_o.out_byte     = tx_byte_i;
              state_o.byte_count = bc_inc;
            end else begin
              // also covers a zero-length write
              res_o.bus_action = ActStop;
              res_o.complete   = 1'b1;
              res_o.success    = 1'b1;
              state_o.active   = 1'b0;
            end
          end else if (status_m == StAddrRAck && is_read) begin
            res_o.bus_action = (state_i.length_left > 6'd1) ? ActRxAck : ActRxNack;
          end else if ((status_m == StDataRAck || status_m == StDataRNack) && is_read) begin
            res_o.rx_valid     = 1'b1;
            res_o.rx_index     = state_i.byte_count[4:0];
            res_o.rx_data      = item_i.bus_rx_byte;
            state_o.byte_count = bc_inc;
            if (status_m == StDataRAck) begin
              // ack while another byte after the next one is wanted
              res_o.bus_action = ((7'(bc_inc) + 7'd1) < 7'(state_i.length_left))
                                 ? ActRxAck : ActRxNack;
            end else begin
              res_o.bus_action = ActStop;
              res_o.complete   = 1'b1;
              res_o.success    = 1'b1;
              state_o.active   = 1'b0;
            end
          end else begin
            res_o.bus_action = ActStop;
            res_o.complete   = 1'b1;
            res_o.success    = 1'b0;
            state_o.active   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res_o.busy_res = state_o.active;
  end

endmodule

// ===== hdl/i2c_master_transaction_sequencer_top.sv =====
// i2c master transaction sequencer: stream in, one result word per input word
// each word passes the input register and then the result register, one word per cycle
// while the output is free; the transmit store read is issued at accept time
// and the sequencer state updates as the input register hands over to the result register
// reset: asynchronous, active low; sequencer idle, counters cleared, no clearing pass
// transmit store contents are undefined until loaded
module i2c_master_transaction_sequencer_top #(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // slave_addr, xfer_length, load_index, load_byte, bus_status, bus_rx_byte, zero fill
  input  logic [i2cs_pkg::InDataW-1:0]   s_axis_tdata,
  // mode
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // accepted, bus_action, out_byte, rx_valid, rx_index, rx_data, complete, success,
  // busy_res, zero fill
  output logic [i2cs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import i2cs_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  item_t      in_item;
  item_t      s1_q;
  logic       s1_v_q;
  result_t    r_q;
  logic       r_v_q;
  seq_state_t st_q;
  seq_state_t st_d;
  seq_state_t step_state;
  result_t    step_res;
  logic [7:0] tx_byte;
  logic       in_fire;
  logic       s1_adv;
  logic       store_we;

  assign in_item.mode        = s_axis_tuser;
  assign in_item.slave_addr  = s_axis_tdata[6:0];
  assign in_item.xfer_length = s_axis_tdata[12:7];
  assign in_item.load_index  = s_axis_tdata[17:13];
  assign in_item.load_byte   = s_axis_tdata[25:18];
  assign in_item.bus_status  = s_axis_tdata[33:26];
  assign in_item.bus_rx_byte = s_axis_tdata[41:34];

  assign s1_adv        = s1_v_q && (!r_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign st_d          = s1_adv ? step_state : st_q;

  // loads go straight into the store, in order with the reads
  assign store_we = in_fire && (in_item.mode == ModeLoad)
                    && (9'(in_item.load_index) < 9'(BUF_DEPTH));

  i2cs_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_tx_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (AW'(in_item.load_index)),
    .wdata_i (in_item.load_byte),
    .re_i    (in_fire),
    .raddr_i (AW'(st_d.byte_count)),
    .rdata_o (tx_byte)
  );

  i2cs_step #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_step (
    .item_i    (s1_q),
    .state_i   (st_q),
    .tx_byte_i (tx_byte),
    .res_o     (step_res),
    .state_o   (step_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      r_v_q  <= 1'b0;
      st_q   <= '0;
    end else begin
      st_q <= st_d;
      if (s_axis_tready) begin
        s1_v_q <= in_fire;
      end
      if (s1_adv) begin
        r_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        r_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item;
    end
    if (s1_adv) begin
      r_q <= step_res;
    end
  end

  assign m_axis_tvalid = r_v_q;
  assign m_axis_tdata  = {3'b000, r_q.busy_res, r_q.success, r_q.complete, r_q.rx_data,
                          r_q.rx_index, r_q.rx_valid, r_q.out_byte, r_q.bus_action,
                          r_q.accepted};

`ifndef NO_ASSERTIONS
  // a transaction only opens on a start word that was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q.active) |-> $past(s1_adv && step_res.accepted))
    else $error("sequencer went busy without an accepted start");

  // a write never counts past its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.active && (st_q.addr_byte[0] != ReadDirBit)) |->
      (st_q.byte_count <= st_q.length_left))
    else $error("write byte count beyond length");

  // a completing result always leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && step_res.complete) |=> (!st_q.active && !r_q.busy_res))
    else $error("completion left the sequencer busy");

  // state moves only when a word passes the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(s1_adv) |-> $stable(st_q))
    else $error("sequencer state changed without a word");
`endif

endmodule
